// ===== hdl/csl_pkg.sv =====
package csl_pkg;

   // Field widths of the transaction payloads
   localparam int CSL_ACTION_W = 3;
   localparam int CSL_DATA_W   = 32;
   localparam int CSL_COUNT_W  = 9;
   localparam int CSL_STATUS_W = 2;

   // Default sizing
   localparam int CSL_CAPACITY   = 256;
   localparam int CSL_VALUE_BITS = 32;

   // Action codes
   localparam logic [CSL_ACTION_W-1:0] ACT_START   = 3'd0;
   localparam logic [CSL_ACTION_W-1:0] ACT_END     = 3'd1;
   localparam logic [CSL_ACTION_W-1:0] ACT_ADVANCE = 3'd2;
   localparam logic [CSL_ACTION_W-1:0] ACT_INSERT  = 3'd3;
   localparam logic [CSL_ACTION_W-1:0] ACT_ATTACH  = 3'd4;
   localparam logic [CSL_ACTION_W-1:0] ACT_REMOVE  = 3'd5;

   // Status codes
   localparam logic [CSL_STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [CSL_STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [CSL_STATUS_W-1:0] ST_NO_ITEM = 2'd2;

   typedef struct packed {
      logic [CSL_ACTION_W-1:0] action;
      logic [CSL_DATA_W-1:0]   entry_value;
   } csl_req_type;

   typedef struct packed {
      logic [CSL_DATA_W-1:0]   current_value;
      logic                    has_item;
      logic [CSL_COUNT_W-1:0]  item_count;
      logic [CSL_STATUS_W-1:0] status;
   } csl_rsp_type;

endpackage

// ===== hdl/cursor_sequence_list.sv =====
// cursor_sequence_list: ordered sequence of up to CAPACITY values with a cursor.
// req channel (req_valid/req_ready/req_data) carries one action per transaction:
// start, end, advance, insert before, attach after, remove current.
// rsp channel (rsp_valid/rsp_ready/rsp_data) returns one transaction per action:
// value at the cursor, cursor flag, entry count and status.
// The list lives in two single-port-read memories (values, links) with a
// registered read; a free chain recycles removed slots.
// Each action passes S_EXEC and S_DONE behind the registered memory read;
// end on four or more entries first walks the links in S_WALK (one link
// read per cycle while walking); advance and remove that move the cursor on
// load its value in S_POST; insert/attach after an entry goes S_ATT, S_POST.
// One action is in flight at a time; req_ready is high only when idle.
// The result sits in an output register: if rsp_ready is low the block still
// accepts the next action and only waits before delivering its result.
// Reset clears the list to empty with no current item; memory contents are
// left as they are and no clearing pass is needed.
module cursor_sequence_list
   import csl_pkg::*;
#(
   parameter int CAPACITY   = CSL_CAPACITY,
   parameter int VALUE_BITS = CSL_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  csl_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output csl_rsp_type rsp_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1; // first read data back, main update
   localparam logic [2:0] S_WALK = 3'd2; // link walk for end
   localparam logic [2:0] S_ATT  = 3'd3; // splice new entry after its predecessor
   localparam logic [2:0] S_POST = 3'd4; // second link write, cursor value load
   localparam logic [2:0] S_DONE = 3'd5; // hand result to output register

   logic [VALUE_BITS-1:0] value_mem [CAPACITY];
   logic [IDX_W-1:0]      link_mem  [CAPACITY];

   logic [2:0]            state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [IDX_W-1:0]      cursor_ff, cursor_in;
   logic                  cv_ff, cv_in;
   logic [IDX_W-1:0]      before_ff, before_in;
   logic                  bv_ff, bv_in;
   logic [CNT_W-1:0]      total_ff, total_in;
   logic [IDX_W-1:0]      free_head_ff, free_head_in;
   logic                  fv_ff, fv_in;
   logic [CNT_W-1:0]      nu_ff, nu_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pend_we_ff, pend_we_in;
   logic                  load_val_ff, load_val_in;

   logic [CSL_ACTION_W-1:0] act_ff, act_in;
   logic [VALUE_BITS-1:0]   val_ff, val_in;
   logic [VALUE_BITS-1:0]   cur_val_ff, cur_val_in;
   logic [IDX_W-1:0]        n_ff, n_in;
   logic [IDX_W-1:0]        prev_ff, prev_in;
   logic [CNT_W-1:0]        walk_ff, walk_in;
   logic [IDX_W-1:0]        pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]        pend_data_ff, pend_data_in;
   logic [CSL_STATUS_W-1:0] status_ff, status_in;
   csl_rsp_type             rsp_data_ff, rsp_data_in;

   // memory ports
   logic                  link_we;
   logic [IDX_W-1:0]      link_waddr, link_wdata, link_raddr, link_rdata_ff;
   logic                  value_we;
   logic [IDX_W-1:0]      value_waddr, value_raddr;
   logic [VALUE_BITS-1:0] value_wdata, value_rdata_ff;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      value_rdata_ff <= value_mem[value_raddr];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic [IDX_W-1:0] slot_n;
      logic [IDX_W-1:0] prev_sel;
      logic             front;

      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      cv_in        = cv_ff;
      before_in    = before_ff;
      bv_in        = bv_ff;
      total_in     = total_ff;
      free_head_in = free_head_ff;
      fv_in        = fv_ff;
      nu_in        = nu_ff;
      pend_we_in   = pend_we_ff;
      load_val_in  = load_val_ff;
      act_in       = act_ff;
      val_in       = val_ff;
      cur_val_in   = cur_val_ff;
      n_in         = n_ff;
      prev_in      = prev_ff;
      walk_in      = walk_ff;
      pend_addr_in = pend_addr_ff;
      pend_data_in = pend_data_ff;
      status_in    = status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      link_we     = 1'b0;
      link_waddr  = n_ff;
      link_wdata  = link_rdata_ff;
      link_raddr  = link_rdata_ff;
      value_we    = 1'b0;
      value_waddr = n_ff;
      value_wdata = val_ff;
      value_raddr = link_rdata_ff;

      // slot taken by insert/attach: free chain first, then never-used slots
      slot_n   = fv_ff ? free_head_ff : IDX_W'(nu_ff);
      front    = (total_ff == '0) ||
                 ((act_ff == ACT_INSERT) && (!cv_ff || (cursor_ff == head_ff) || !bv_ff));
      prev_sel = (act_ff == ACT_INSERT) ? before_ff : (cv_ff ? cursor_ff : tail_ff);

      unique case (state_ff)
         S_IDLE: begin
            unique case (req_data.action)
               ACT_START: begin
                  value_raddr = head_ff;
               end
               ACT_END: begin
                  link_raddr  = head_ff;
                  value_raddr = tail_ff;
               end
               ACT_INSERT, ACT_ATTACH: begin
                  link_raddr = free_head_ff; // successor on the free chain
               end
               default: begin
                  link_raddr = cursor_ff;
               end
            endcase
            if (req_valid) begin
               act_in    = req_data.action;
               val_in    = VALUE_BITS'(req_data.entry_value);
               status_in = ST_DONE;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            unique case (act_ff)
               ACT_START: begin
                  if (total_ff != '0) begin
                     cursor_in  = head_ff;
                     cv_in      = 1'b1;
                     bv_in      = 1'b0;
                     before_in  = '0;
                     cur_val_in = value_rdata_ff;
                  end
               end

               ACT_END: begin
                  if (total_ff == CNT_W'(1)) begin
                     cursor_in  = head_ff;
                     cv_in      = 1'b1;
                     bv_in      = 1'b0;
                     before_in  = '0;
                     cur_val_in = value_rdata_ff;
                  end else if (total_ff > CNT_W'(1)) begin
                     cursor_in  = tail_ff;
                     cv_in      = 1'b1;
                     bv_in      = 1'b1;
                     cur_val_in = value_rdata_ff;
                     if (total_ff == CNT_W'(2)) begin
                        before_in = head_ff;
                     end else if (total_ff == CNT_W'(3)) begin
                        before_in = link_rdata_ff;
                     end else begin
                        link_raddr = link_rdata_ff;
                        walk_in    = total_ff - CNT_W'(4);
                        state_in   = S_WALK;
                     end
                  end
               end

               ACT_ADVANCE: begin
                  if (cv_ff) begin
                     if (cursor_ff == tail_ff) begin
                        cv_in     = 1'b0;
                        bv_in     = 1'b0;
                        cursor_in = '0;
                        before_in = '0;
                     end else begin
                        before_in   = cursor_ff;
                        bv_in       = 1'b1;
                        cursor_in   = link_rdata_ff;
                        value_raddr = link_rdata_ff;
                        load_val_in = 1'b1;
                        pend_we_in  = 1'b0;
                        state_in    = S_POST;
                     end
                  end
               end

               ACT_INSERT, ACT_ATTACH: begin
                  if (total_ff >= CAP_CNT) begin
                     status_in = ST_FULL;
                  end else begin
                     n_in = slot_n;
                     if (fv_ff) begin
                        free_head_in = link_rdata_ff;
                        fv_in        = (nu_ff - total_ff) > CNT_W'(1);
                     end else begin
                        nu_in = nu_ff + CNT_W'(1);
                     end
                     value_we    = 1'b1;
                     value_waddr = slot_n;
                     value_wdata = val_ff;
                     cur_val_in  = val_ff;
                     total_in    = total_ff + CNT_W'(1);
                     cursor_in   = slot_n;
                     cv_in       = 1'b1;
                     if (front) begin
                        link_we    = 1'b1;
                        link_waddr = slot_n;
                        link_wdata = head_ff;
                        head_in    = slot_n;
                        if (total_ff == '0) begin
                           tail_in = slot_n;
                        end
                        bv_in     = 1'b0;
                        before_in = '0;
                     end else begin
                        link_raddr = prev_sel;
                        prev_in    = prev_sel;
                        if (prev_sel == tail_ff) begin
                           tail_in = slot_n;
                        end
                        before_in = prev_sel;
                        bv_in     = 1'b1;
                        state_in  = S_ATT;
                     end
                  end
               end

               ACT_REMOVE: begin
                  if (!cv_ff || (total_ff == '0)) begin
                     status_in = ST_NO_ITEM;
                  end else begin
                     // released slot goes on the free chain
                     link_we      = 1'b1;
                     link_waddr   = cursor_ff;
                     link_wdata   = free_head_ff;
                     free_head_in = cursor_ff;
                     fv_in        = 1'b1;
                     total_in     = total_ff - CNT_W'(1);
                     if (cursor_ff == head_ff) begin
                        bv_in     = 1'b0;
                        before_in = '0;
                        if (total_ff == CNT_W'(1)) begin
                           head_in   = '0;
                           tail_in   = '0;
                           cv_in     = 1'b0;
                           cursor_in = '0;
                        end else begin
                           head_in     = link_rdata_ff;
                           cursor_in   = link_rdata_ff;
                           value_raddr = link_rdata_ff;
                           load_val_in = 1'b1;
                           pend_we_in  = 1'b0;
                           state_in    = S_POST;
                        end
                     end else if (cursor_ff == tail_ff) begin
                        tail_in   = before_ff;
                        cv_in     = 1'b0;
                        bv_in     = 1'b0;
                        cursor_in = '0;
                        before_in = '0;
                     end else begin
                        cursor_in    = link_rdata_ff;
                        value_raddr  = link_rdata_ff;
                        load_val_in  = 1'b1;
                        pend_we_in   = 1'b1;
                        pend_addr_in = before_ff;
                        pend_data_in = link_rdata_ff;
                        state_in     = S_POST;
                     end
                  end
               end

               default: begin
               end
            endcase
         end

         S_WALK: begin
            if (walk_ff == '0) begin
               before_in = link_rdata_ff;
               state_in  = S_DONE;
            end else begin
               link_raddr = link_rdata_ff;
               walk_in    = walk_ff - CNT_W'(1);
            end
         end

         S_ATT: begin
            // new entry takes over the predecessor's successor
            link_we      = 1'b1;
            link_waddr   = n_ff;
            link_wdata   = link_rdata_ff;
            pend_we_in   = 1'b1;
            pend_addr_in = prev_ff;
            pend_data_in = n_ff;
            load_val_in  = 1'b0;
            state_in     = S_POST;
         end

         S_POST: begin
            if (pend_we_ff) begin
               link_we    = 1'b1;
               link_waddr = pend_addr_ff;
               link_wdata = pend_data_ff;
            end
            if (load_val_ff) begin
               cur_val_in = value_rdata_ff;
            end
            pend_we_in  = 1'b0;
            load_val_in = 1'b0;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.current_value = cv_ff ? CSL_DATA_W'(cur_val_ff) : '0;
               rsp_data_in.has_item      = cv_ff;
               rsp_data_in.item_count    = CSL_COUNT_W'(total_ff);
               rsp_data_in.status        = status_ff;
               state_in                  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cursor_ff    <= '0;
         cv_ff        <= 1'b0;
         before_ff    <= '0;
         bv_ff        <= 1'b0;
         total_ff     <= '0;
         free_head_ff <= '0;
         fv_ff        <= 1'b0;
         nu_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pend_we_ff   <= 1'b0;
         load_val_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         cv_ff        <= cv_in;
         before_ff    <= before_in;
         bv_ff        <= bv_in;
         total_ff     <= total_in;
         free_head_ff <= free_head_in;
         fv_ff        <= fv_in;
         nu_ff        <= nu_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_we_ff   <= pend_we_in;
         load_val_ff  <= load_val_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      val_ff       <= val_in;
      cur_val_ff   <= cur_val_in;
      n_ff         <= n_in;
      prev_ff      <= prev_in;
      walk_ff      <= walk_in;
      pend_addr_ff <= pend_addr_in;
      pend_data_ff <= pend_data_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // a current item implies a non-empty list
   assert property (@(posedge clock) disable iff (reset) cv_ff |-> (total_ff != '0))
      else $error("cursor valid on an empty list");

   assert property (@(posedge clock) disable iff (reset) total_ff <= CAP_CNT)
      else $error("entry count beyond capacity");

   // empty free chain means every slot ever handed out is still live
   assert property (@(posedge clock) disable iff (reset) !fv_ff |-> (nu_ff == total_ff))
      else $error("free chain empty but slots missing");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (status_ff == ST_FULL)) |-> (total_ff == CAP_CNT))
      else $error("full status on a list with room");

endmodule

// ===== bench/tb.sv =====
module tb
   import csl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Index width of the list memories; slot arithmetic wraps at this width
   localparam int IDX_W = $clog2(CSL_CAPACITY);

   // Codes the block must treat as no-ops
   localparam logic [CSL_ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [CSL_ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam int TOTAL_ITEMS = 1400;
   // Longest quiet spell: a tail search over a full store plus both stalls,
   // taken several times over
   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 300;

   typedef enum {PLAN_MIXED, PLAN_GROW, PLAN_DRAIN} plan_type;

   // ---------------------------------------------------------------------
   // Shadow of the list: mirrors head/tail/cursor, the free chain and the
   // two memories, and holds the views the block should report, in order.
   // ---------------------------------------------------------------------
   class list_tracker;
      logic [CSL_DATA_W-1:0] value_mem [CSL_CAPACITY];
      logic [IDX_W-1:0]      link_mem  [CSL_CAPACITY];
      logic [IDX_W-1:0]      head_idx, tail_idx, cur_idx, prev_idx, free_top;
      bit                    cur_ok, prev_ok, free_ok;
      logic [CSL_COUNT_W-1:0] total;
      logic [IDX_W:0]        fresh_next;
      csl_rsp_type           expected_views[$];
      int unsigned           errors;

      function new();
         foreach (value_mem[i]) begin
            value_mem[i] = '0;
            link_mem[i]  = '0;
         end
         head_idx = '0; tail_idx = '0; cur_idx = '0; prev_idx = '0;
         free_top = '0; cur_ok = 0; prev_ok = 0; free_ok = 0;
         total = '0; fresh_next = '0; errors = 0;
      endfunction

      // Pop the free chain if it holds anything, else use a fresh slot
      function logic [IDX_W-1:0] take_slot();
         logic [IDX_W-1:0] s;
         if (free_ok) begin
            s = free_top;
            free_top = link_mem[s];
            free_ok = (fresh_next - total) > 1;
         end else begin
            s = fresh_next[IDX_W-1:0];
            fresh_next++;
         end
         return s;
      endfunction

      function void put_front(logic [IDX_W-1:0] n);
         link_mem[n] = head_idx;
         head_idx = n;
         if (total == 0)
            tail_idx = n;
         cur_idx = n;
         cur_ok = 1;
         prev_ok = 0;
         prev_idx = '0;
      endfunction

      function void put_after(logic [IDX_W-1:0] p, logic [IDX_W-1:0] n);
         link_mem[n] = link_mem[p];
         link_mem[p] = n;
         if (p == tail_idx)
            tail_idx = n;
         prev_idx = p;
         prev_ok = 1;
         cur_idx = n;
         cur_ok = 1;
      endfunction

      // Apply one accepted action and queue the view it should produce
      function void log_action(csl_req_type r);
         logic [IDX_W-1:0] n, p, c;
         logic [CSL_STATUS_W-1:0] st;
         csl_rsp_type v;
         st = ST_DONE;
         case (r.action)
            ACT_START: begin
               if (total != 0) begin
                  cur_idx = head_idx;
                  cur_ok = 1;
                  prev_ok = 0;
                  prev_idx = '0;
               end
            end
            ACT_END: begin
               if (total == 1) begin
                  cur_idx = head_idx;
                  cur_ok = 1;
                  prev_ok = 0;
                  prev_idx = '0;
               end else if (total > 1) begin
                  p = head_idx;
                  for (int k = 0; k + 2 < total; k++)
                     p = link_mem[p];
                  prev_idx = p;
                  prev_ok = 1;
                  cur_idx = tail_idx;
                  cur_ok = 1;
               end
            end
            ACT_ADVANCE: begin
               if (cur_ok) begin
                  if (cur_idx == tail_idx) begin
                     cur_ok = 0;
                     prev_ok = 0;
                     cur_idx = '0;
                     prev_idx = '0;
                  end else begin
                     prev_idx = cur_idx;
                     prev_ok = 1;
                     cur_idx = link_mem[cur_idx];
                  end
               end
            end
            ACT_INSERT, ACT_ATTACH: begin
               if (total >= CSL_CAPACITY) begin
                  st = ST_FULL;
               end else begin
                  n = take_slot();
                  value_mem[n] = r.entry_value;
                  if (total == 0)
                     put_front(n);
                  else if (r.action == ACT_INSERT) begin
                     // no usable predecessor: the new entry becomes the head
                     if (!cur_ok || cur_idx == head_idx || !prev_ok)
                        put_front(n);
                     else
                        put_after(prev_idx, n);
                  end else
                     put_after(cur_ok ? cur_idx : tail_idx, n);
                  total++;
               end
            end
            ACT_REMOVE: begin
               if (!cur_ok || total == 0) begin
                  st = ST_NO_ITEM;
               end else begin
                  c = cur_idx;
                  if (c == head_idx) begin
                     if (total == 1) begin
                        head_idx = '0;
                        tail_idx = '0;
                        cur_ok = 0;
                        cur_idx = '0;
                     end else begin
                        head_idx = link_mem[c];
                        cur_idx = head_idx;
                     end
                     prev_ok = 0;
                     prev_idx = '0;
                  end else if (c == tail_idx) begin
                     // dropping the tail leaves no current item
                     tail_idx = prev_idx;
                     cur_ok = 0;
                     prev_ok = 0;
                     cur_idx = '0;
                     prev_idx = '0;
                  end else begin
                     cur_idx = link_mem[c];
                     link_mem[prev_idx] = cur_idx;
                  end
                  link_mem[c] = free_top;
                  free_top = c;
                  free_ok = 1;
                  total--;
               end
            end
            default: ;
         endcase
         v.current_value = cur_ok ? value_mem[cur_idx] : '0;
         v.has_item      = cur_ok;
         v.item_count    = total;
         v.status        = st;
         expected_views.push_back(v);
      endfunction

      function void flag(string name, logic [CSL_DATA_W-1:0] want_v,
                         logic [CSL_DATA_W-1:0] got_v);
         if (want_v !== got_v) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
         end
      endfunction

      function void check_view(csl_rsp_type got);
         csl_rsp_type want;
         if (expected_views.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding, expected none actual %p",
                     $time, got);
            return;
         end
         want = expected_views.pop_front();
         flag("current_value", want.current_value, got.current_value);
         flag("has_item", want.has_item, got.has_item);
         flag("item_count", want.item_count, got.item_count);
         flag("status", want.status, got.status);
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and the signals into the block; all known from time zero
   // ---------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   csl_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   csl_rsp_type rsp_data;

   list_tracker ledger = new();
   int unsigned issued = 0;
   int unsigned quiet_cycles = 0;
   bit          req_calm = 0;
   bit          rsp_calm = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   cursor_sequence_list uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Request side. Each transaction waits a drawn gap first; with no gap
   // valid simply stays high into the next transaction. Every so often the
   // sender goes calm for a stretch so back-to-back traffic is seen too.
   // ---------------------------------------------------------------------
   task automatic push_action(logic [CSL_ACTION_W-1:0] act, logic [CSL_DATA_W-1:0] val);
      csl_req_type item;
      int unsigned gap;
      item.action = act;
      item.entry_value = val;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      // accepted at this edge: the shadow list moves on
      ledger.log_action(item);
      issued++;
      if (issued % 64 == 0)
         req_calm = ($urandom_range(0, 3) == 0);
   endtask

   // Pick an action weighted by the current plan; values lean on the extremes
   task automatic random_action(plan_type plan);
      int unsigned roll, pick;
      logic [CSL_ACTION_W-1:0] act;
      logic [CSL_DATA_W-1:0] val;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 15);
      case (plan)
         PLAN_GROW:
            act = roll < 40 ? ACT_INSERT : roll < 75 ? ACT_ATTACH :
                  roll < 87 ? ACT_ADVANCE : roll < 92 ? ACT_START :
                  roll < 95 ? ACT_END : ACT_REMOVE;
         PLAN_DRAIN:
            act = roll < 55 ? ACT_REMOVE : roll < 70 ? ACT_START :
                  roll < 88 ? ACT_ADVANCE : roll < 92 ? ACT_END :
                  roll < 96 ? ACT_INSERT : ACT_ATTACH;
         default:
            act = roll < 8 ? ACT_START : roll < 14 ? ACT_END :
                  roll < 32 ? ACT_ADVANCE : roll < 50 ? ACT_INSERT :
                  roll < 66 ? ACT_ATTACH : roll < 94 ? ACT_REMOVE :
                  roll < 97 ? ACT_SPARE_6 : ACT_SPARE_7;
      endcase
      val = pick == 0 ? '0 : pick == 1 ? '1 : $urandom();
      push_action(act, val);
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall a drawn number of cycles, then take one result and
   // check it against the oldest expected view
   // ---------------------------------------------------------------------
   initial begin : result_side
      int unsigned stall, taken;
      taken = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = rsp_calm ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         ledger.check_view(rsp_data);
         taken++;
         if (taken % 64 == 0)
            rsp_calm = ($urandom_range(0, 3) == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles with no transaction on either channel
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list no-ops, spare codes, insert/attach with and
      // without a cursor, stepping off the tail, tail search, removal of
      // head, middle and tail, and slot reuse from the free chain.
      push_action(ACT_START,   '0);
      push_action(ACT_END,     '0);
      push_action(ACT_ADVANCE, '0);
      push_action(ACT_REMOVE,  '1);
      push_action(ACT_SPARE_6, '0);
      push_action(ACT_SPARE_7, '1);
      push_action(ACT_INSERT,  '0);
      push_action(ACT_ATTACH,  '1);
      push_action(ACT_ADVANCE, '0);
      push_action(ACT_ATTACH,  32'h8000_0000);
      push_action(ACT_ADVANCE, '0);
      push_action(ACT_INSERT,  32'h0000_0001);
      push_action(ACT_END,     '0);
      push_action(ACT_INSERT,  32'h5555_5555);
      push_action(ACT_ADVANCE, '0);
      push_action(ACT_REMOVE,  '0);
      push_action(ACT_START,   '0);
      push_action(ACT_REMOVE,  '0);
      push_action(ACT_ADVANCE, '0);
      push_action(ACT_REMOVE,  '0);
      push_action(ACT_ATTACH,  32'hAAAA_AAAA);
      push_action(ACT_START,   '0);
      push_action(ACT_INSERT,  32'h1234_5678);
      push_action(ACT_END,     '0);
      push_action(ACT_REMOVE,  '0);

      // Random: a mixed warm-up, fill to capacity and push against the full
      // store (tail searches over the whole list included), drain back to
      // empty or until 1300 actions are issued, then mixed traffic to the end.
      repeat (250) random_action(PLAN_MIXED);
      while (ledger.total < CSL_CAPACITY) random_action(PLAN_GROW);
      repeat (30) random_action(PLAN_GROW);
      while (ledger.total != 0 && issued < 1300) random_action(PLAN_DRAIN);
      while (issued < TOTAL_ITEMS) random_action(PLAN_MIXED);
      req_valid <= 1'b0;

      while (ledger.expected_views.size() != 0) @(posedge clock);
      // catch any stray result after the last one expected
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/csl_pkg.sv
hdl/cursor_sequence_list.sv
bench/tb.sv
